>>> hw/rtl/ahdsr_pkg.sv
// shared constants for the envelope scaler
`timescale 1ns / 1ps

package ahdsr_pkg;

    localparam int COUNT_WIDTH_DEF  = 24;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_W    = 17;
    localparam int MIX_W     = 24;
    // sum of four 24-bit durations
    localparam int BOUND_W   = CFG_W + 2;

    // shared multiplier operands and the product kept for the divider
    localparam int MUL_A_W   = CFG_W + 1;
    localparam int MUL_B_W   = GAIN_W + 1;
    localparam int PROD_W    = CFG_W + GAIN_W;
    localparam int DIV_CNT_W = $clog2(GAIN_W);

    localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd5;

endpackage

>>> hw/rtl/ahdsr_in_if.sv
// input channel: instrument sample, mix value and note markers
`timescale 1ns / 1ps

interface ahdsr_in_if #(
    parameter int SAMPLE_WIDTH = ahdsr_pkg::SAMPLE_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [SAMPLE_WIDTH-1:0]    base_sample;
    logic signed [ahdsr_pkg::MIX_W-1:0] mix_in;
    logic                              note_start;
    logic                              release_now;

    modport source (
        output valid, base_sample, mix_in, note_start, release_now,
        input  ready
    );
    modport sink (
        input  valid, base_sample, mix_in, note_start, release_now,
        output ready
    );
endinterface

>>> hw/rtl/ahdsr_out_if.sv
// output channel: shaped mix value and note end flag
`timescale 1ns / 1ps

interface ahdsr_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ahdsr_pkg::MIX_W-1:0] mix_out;
    logic                              note_ended;

    modport source (output valid, mix_out, note_ended, input ready);
    modport sink (input valid, mix_out, note_ended, output ready);
endinterface

>>> hw/rtl/ahdsr_envelope_scaler.sv
// Envelope scaler top level: one shared multiplier and divider under a sequencer.
// Each item adds base_sample times a Q16 envelope gain (delay, attack, hold, decay,
// sustain, release) to mix_in, saturated to 24 bits. When the note has ended, an item goes
// from the accept step straight to a final multiply and a saturating add. Otherwise it
// takes the accept step, a phase search over the delay, attack, hold and decay bounds, and
// for each ramp fraction one multiply, then a 17-step restoring divide on the same unit.
// There is one ramp fraction for the attack or decay ramp and one more for the release
// ramp. The release state is checked, and the final multiply and the saturating add
// close the item. The add waits while the output register is still full. The input is
// not ready while an item is in work; a finished result sits in an output register so
// the next item can be taken while it waits. Durations are in samples; both sample
// counters saturate. Configuration writes take effect at once and are meant for idle.
`timescale 1ns / 1ps

module ahdsr_envelope_scaler #(
    parameter int COUNT_WIDTH  = ahdsr_pkg::COUNT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = ahdsr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ahdsr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ahdsr_pkg::CFG_W-1:0]        i_cfg_data,
    ahdsr_in_if.sink                           i_in,
    ahdsr_out_if.source                        o_out
);

    localparam int CFG_W   = ahdsr_pkg::CFG_W;
    localparam int GAIN_W  = ahdsr_pkg::GAIN_W;
    localparam int MIX_W   = ahdsr_pkg::MIX_W;
    localparam int BOUND_W = ahdsr_pkg::BOUND_W;
    localparam int PROD_W  = ahdsr_pkg::PROD_W;
    localparam int MUL_A_W = ahdsr_pkg::MUL_A_W;
    localparam int MUL_B_W = ahdsr_pkg::MUL_B_W;
    localparam int CNT_W   = ahdsr_pkg::DIV_CNT_W;
    localparam int CMP_W   = (COUNT_WIDTH > BOUND_W) ? COUNT_WIDTH : BOUND_W;
    localparam int SUM_W   = MIX_W + 2;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PHASE = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_REL   = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_SUM   = 7'b1000000
    } t_state;

    // configuration
    logic [CFG_W-1:0]  r_delay, r_attack, r_hold, r_decay, r_release;
    logic [GAIN_W-1:0] r_sustain;

    // envelope state
    logic [COUNT_WIDTH-1:0] r_on_cnt, r_off_cnt;
    logic                   r_released, r_ended;

    // sequencer
    t_state                 r_state;
    logic [1:0]             r_k;
    logic [BOUND_W-1:0]     r_bound;
    logic                   r_live;
    logic                   r_rel_pass;
    logic [CNT_W-1:0]       r_cnt;

    // item payload and shared unit operands
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic signed [MIX_W-1:0]        r_mix;
    logic [CFG_W-1:0]               r_mx;
    logic [GAIN_W-1:0]              r_my;
    logic [CFG_W-1:0]               r_div;
    logic [GAIN_W-1:0]              r_add;
    logic [GAIN_W-1:0]              r_gain;
    logic [CFG_W-1:0]               r_rem;
    logic [GAIN_W-1:0]              r_q;

    // output register
    logic                    r_out_valid;
    logic signed [MIX_W-1:0] r_mix_out;
    logic                    r_note_ended;

    logic accept;
    logic n_start_ended;
    logic n_released;

    logic [GAIN_W-1:0]  sustain_clamped;
    logic [CFG_W-1:0]   cfg_sel;
    logic [BOUND_W-1:0] bound_n;
    logic [CMP_W-1:0]   on_ext, bnd_ext, old_bnd_ext, off_ext, rel_ext;
    logic [CMP_W-1:0]   att_diff, dec_diff, rel_diff;
    logic               phase_lt, rel_over;

    logic signed [MUL_A_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;

    logic [CFG_W:0]      div_trial;
    logic [CFG_W:0]      div_diff;
    logic                div_ge;
    logic [CFG_W-1:0]    div_rem_n;
    logic [GAIN_W-1:0]   div_q_n;
    logic [GAIN_W:0]     div_gain;

    logic signed [CFG_W:0]   prod_q;
    logic signed [SUM_W-1:0] mix_sum;
    logic signed [MIX_W-1:0] mix_sat;
    logic                    out_free;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.mix_out    = r_mix_out;
    assign o_out.note_ended = r_note_ended;

    assign n_start_ended = i_in.note_start ? 1'b0 : r_ended;
    assign n_released    = i_in.release_now || (!i_in.note_start && r_released);

    assign sustain_clamped = (r_sustain > ahdsr_pkg::UNITY) ? ahdsr_pkg::UNITY : r_sustain;

    // phase boundaries are accumulated one duration per step
    always_comb begin
        case (r_k)
            2'd0:    cfg_sel = r_delay;
            2'd1:    cfg_sel = r_attack;
            2'd2:    cfg_sel = r_hold;
            default: cfg_sel = r_decay;
        endcase
    end

    assign bound_n     = r_bound + BOUND_W'(cfg_sel);
    assign on_ext      = CMP_W'(r_on_cnt);
    assign bnd_ext     = CMP_W'(bound_n);
    assign old_bnd_ext = CMP_W'(r_bound);
    assign phase_lt    = on_ext < bnd_ext;
    assign att_diff    = on_ext - old_bnd_ext;
    // decay numerator: decay length minus time into decay is end of decay minus t
    assign dec_diff    = bnd_ext - on_ext;

    assign off_ext  = CMP_W'(r_off_cnt);
    assign rel_ext  = CMP_W'(r_release);
    assign rel_over = off_ext > rel_ext;
    assign rel_diff = rel_ext - off_ext;

    // shared multiplier: ramp numerators, then the sample times gain
    always_comb begin
        if (r_state == S_FIN) begin
            mul_a = MUL_A_W'(r_sample);
            mul_b = $signed({1'b0, r_gain});
        end else begin
            mul_a = $signed({1'b0, r_mx});
            mul_b = $signed({1'b0, r_my});
        end
    end
    assign mul_p = mul_a * mul_b;

    // restoring divide, one quotient bit per cycle
    assign div_trial = {r_rem, r_q[GAIN_W-1]};
    assign div_diff  = div_trial - {1'b0, r_div};
    assign div_ge    = div_trial >= {1'b0, r_div};
    assign div_rem_n = div_ge ? div_diff[CFG_W-1:0] : div_trial[CFG_W-1:0];
    assign div_q_n   = {r_q[GAIN_W-2:0], div_ge};
    assign div_gain  = {1'b0, div_q_n} + {1'b0, r_add};

    // floor of product over 2^16, then saturating add
    assign prod_q  = $signed({r_rem, r_q[GAIN_W-1]});
    assign mix_sum = SUM_W'(r_mix) + SUM_W'(prod_q);

    always_comb begin
        if (mix_sum[SUM_W-1:MIX_W-1] == '0 || mix_sum[SUM_W-1:MIX_W-1] == '1) begin
            mix_sat = mix_sum[MIX_W-1:0];
        end else if (mix_sum[SUM_W-1]) begin
            mix_sat = {1'b1, {(MIX_W-1){1'b0}}};
        end else begin
            mix_sat = {1'b0, {(MIX_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay   <= '0;
            r_attack  <= '0;
            r_hold    <= '0;
            r_decay   <= '0;
            r_sustain <= ahdsr_pkg::UNITY;
            r_release <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ahdsr_pkg::REG_DELAY:   r_delay   <= i_cfg_data;
                ahdsr_pkg::REG_ATTACK:  r_attack  <= i_cfg_data;
                ahdsr_pkg::REG_HOLD:    r_hold    <= i_cfg_data;
                ahdsr_pkg::REG_DECAY:   r_decay   <= i_cfg_data;
                ahdsr_pkg::REG_SUSTAIN: r_sustain <= i_cfg_data[GAIN_W-1:0];
                ahdsr_pkg::REG_RELEASE: r_release <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result is loaded from the add step, otherwise it clears once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_SUM && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_on_cnt    <= '0;
            r_off_cnt   <= '0;
            r_released  <= 1'b0;
            r_ended     <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sample   <= i_in.base_sample;
                        r_mix      <= i_in.mix_in;
                        r_ended    <= n_start_ended;
                        r_released <= n_released;
                        r_live     <= !n_start_ended;
                        if (i_in.note_start) begin
                            r_on_cnt <= '0;
                        end
                        if (i_in.note_start || i_in.release_now) begin
                            r_off_cnt <= '0;
                        end
                        r_bound    <= '0;
                        r_k        <= 2'd0;
                        r_rel_pass <= 1'b0;
                        r_gain     <= '0;
                        r_state    <= n_start_ended ? S_FIN : S_PHASE;
                    end
                end
                S_PHASE: begin
                    r_bound <= bound_n;
                    r_k     <= r_k + 2'd1;
                    case (r_k)
                        2'd0: begin
                            if (phase_lt) begin
                                r_gain  <= '0;
                                r_state <= S_REL;
                            end
                        end
                        2'd1: begin
                            if (phase_lt) begin
                                r_mx    <= att_diff[CFG_W-1:0];
                                r_my    <= ahdsr_pkg::UNITY;
                                r_div   <= r_attack;
                                r_add   <= '0;
                                r_state <= S_MUL;
                            end
                        end
                        2'd2: begin
                            if (phase_lt) begin
                                r_gain  <= ahdsr_pkg::UNITY;
                                r_state <= S_REL;
                            end
                        end
                        default: begin
                            if (phase_lt) begin
                                r_mx    <= dec_diff[CFG_W-1:0];
                                r_my    <= ahdsr_pkg::UNITY - sustain_clamped;
                                r_div   <= r_decay;
                                r_add   <= sustain_clamped;
                                r_state <= S_MUL;
                            end else begin
                                // zero sustain ends the note
                                if (sustain_clamped == '0) begin
                                    r_ended <= 1'b1;
                                end
                                r_gain  <= sustain_clamped;
                                r_state <= S_REL;
                            end
                        end
                    endcase
                end
                S_MUL: begin
                    {r_rem, r_q} <= mul_p[PROD_W-1:0];
                    r_cnt        <= CNT_W'(GAIN_W - 1);
                    r_state      <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= div_rem_n;
                    r_q   <= div_q_n;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_gain  <= div_gain[GAIN_W-1:0];
                        r_state <= r_rel_pass ? S_FIN : S_REL;
                    end
                end
                S_REL: begin
                    if (!r_released) begin
                        r_state <= S_FIN;
                    end else if (r_release == '0 || rel_over) begin
                        r_ended <= 1'b1;
                        r_gain  <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_mx       <= rel_diff[CFG_W-1:0];
                        r_my       <= r_gain;
                        r_div      <= r_release;
                        r_add      <= '0;
                        r_rel_pass <= 1'b1;
                        r_state    <= S_MUL;
                    end
                end
                S_FIN: begin
                    if (r_ended) begin
                        r_gain <= '0;
                    end
                    {r_rem, r_q} <= r_ended ? '0 : mul_p[PROD_W-1:0];
                    r_state      <= S_SUM;
                end
                S_SUM: begin
                    if (out_free) begin
                        r_mix_out    <= mix_sat;
                        r_note_ended <= r_ended;
                        if (r_live) begin
                            if (r_on_cnt != '1) begin
                                r_on_cnt <= r_on_cnt + 1'b1;
                            end
                            if (r_released && r_off_cnt != '1) begin
                                r_off_cnt <= r_off_cnt + 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a ramp fraction never divides by zero
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("ramp divide with zero length");

    // partial remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("divider remainder out of range");

    // gain never exceeds unity when the sample is scaled
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_gain <= ahdsr_pkg::UNITY))
        else $error("gain above unity");

    // release counter only runs after a note-off
    a_off_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_off_cnt != '0) |-> r_released)
        else $error("release counter running without note-off");

endmodule

>>> tb/sv/ahdsr_envelope_scaler_test.sv
// self-checking testbench for the envelope scaler: random notes checked against a predictor
`timescale 1ns / 1ps

module ahdsr_envelope_scaler_test;

    localparam int          SW           = ahdsr_pkg::SAMPLE_WIDTH_DEF;
    localparam int          MIX_W        = ahdsr_pkg::MIX_W;
    localparam int          CFG_W        = ahdsr_pkg::CFG_W;
    localparam int          CFG_IDX_W    = ahdsr_pkg::CFG_IDX_W;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 50;
    localparam int          SETTINGS_CNT = 12;
    localparam longint unsigned DUR_MAX  = 64'd16777215;

    typedef struct packed {
        logic signed [SW-1:0]    base_sample;
        logic signed [MIX_W-1:0] mix_in;
        logic                    note_start;
        logic                    release_now;
    } t_sample_item;

    typedef struct packed {
        logic signed [MIX_W-1:0] mix_out;
        logic                    note_ended;
    } t_mix_result;

    // envelope predictor and the queue of mix values it expects
    class t_envelope_scoreboard;
        localparam longint unsigned Q16_ONE   = 64'd65536;
        localparam longint unsigned COUNT_TOP = (64'd1 << ahdsr_pkg::COUNT_WIDTH_DEF) - 1;
        localparam longint          MIX_HI    = 64'sd8388607;
        localparam longint          MIX_LO    = -64'sd8388608;

        longint unsigned env_reg [6];
        longint unsigned on_count;
        longint unsigned off_count;
        bit              released;
        bit              ended;
        t_mix_result     expected_mix_q [$];
        int              errors;
        int              checked;

        function new();
            env_reg   = '{0, 0, 0, 0, 65536, 0};
            on_count  = 0;
            off_count = 0;
            released  = 0;
            ended     = 1;
            errors    = 0;
            checked   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
            if (idx == ahdsr_pkg::REG_SUSTAIN) begin
                env_reg[idx] = val & 64'h1FFFF;
            end else begin
                env_reg[idx] = val & 64'hFFFFFF;
            end
        endfunction

        function t_mix_result shape_sample(t_sample_item it);
            longint          smp;
            longint          mix;
            longint          res;
            longint          prod;
            longint unsigned t, d, a, h, dc, s, g, u, r, rel, att, dec, sus;
            t_mix_result     o;
            smp = it.base_sample;
            mix = it.mix_in;
            res = mix;
            if (it.note_start) begin
                on_count  = 0;
                off_count = 0;
                released  = 0;
                ended     = 0;
            end
            if (it.release_now) begin
                released  = 1;
                off_count = 0;
            end
            if (!ended) begin
                att = env_reg[ahdsr_pkg::REG_ATTACK];
                dec = env_reg[ahdsr_pkg::REG_DECAY];
                sus = env_reg[ahdsr_pkg::REG_SUSTAIN];
                t   = on_count;
                d   = env_reg[ahdsr_pkg::REG_DELAY];
                a   = d + att;
                h   = a + env_reg[ahdsr_pkg::REG_HOLD];
                dc  = h + dec;
                s   = (sus > Q16_ONE) ? Q16_ONE : sus;
                rel = env_reg[ahdsr_pkg::REG_RELEASE];
                if (t < d) begin
                    g = 0;
                end else if (t < a) begin
                    g = ((t - d) * Q16_ONE) / att;
                end else if (t < h) begin
                    g = Q16_ONE;
                end else if (t < dc) begin
                    u = t - h;
                    g = s + ((dec - u) * (Q16_ONE - s)) / dec;
                end else if (s == 0) begin
                    ended = 1;
                    g     = 0;
                end else begin
                    g = s;
                end
                if (released) begin
                    r = off_count;
                    if (rel == 0 || r > rel) begin
                        ended = 1;
                        g     = 0;
                    end else begin
                        g = (g * (rel - r)) / rel;
                    end
                end
                if (!ended) begin
                    // arithmetic shift floors the negative products
                    prod = smp * longint'(g);
                    res  = mix + (prod >>> 16);
                    if (res > MIX_HI) res = MIX_HI;
                    if (res < MIX_LO) res = MIX_LO;
                end
                if (on_count < COUNT_TOP) on_count++;
                if (released && off_count < COUNT_TOP) off_count++;
            end
            o.mix_out    = res[MIX_W-1:0];
            o.note_ended = ended;
            return o;
        endfunction

        function void note_sample(t_sample_item it);
            expected_mix_q.push_back(shape_sample(it));
        endfunction

        function void check_mix(logic signed [MIX_W-1:0] mix, logic done);
            t_mix_result want;
            if (expected_mix_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected item mix_out %0d note_ended %0b", $time, mix, done);
                return;
            end
            want = expected_mix_q.pop_front();
            checked++;
            if (mix !== want.mix_out) begin
                errors++;
                $display("%0t: mix_out expected %0d actual %0d", $time, want.mix_out, mix);
            end
            if (done !== want.note_ended) begin
                errors++;
                $display("%0t: note_ended expected %0b actual %0b",
                         $time, want.note_ended, done);
            end
        endfunction

        function int pending();
            return expected_mix_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;

    ahdsr_in_if #(.SAMPLE_WIDTH(SW)) in_ch ();
    ahdsr_out_if                     out_ch ();

    ahdsr_envelope_scaler #(
        .COUNT_WIDTH  (ahdsr_pkg::COUNT_WIDTH_DEF),
        .SAMPLE_WIDTH (SW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    t_envelope_scoreboard sb;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    bit                 hold_req;
    int                 hold_left;
    int                 stall_cycles;
    int                 items_sent;
    int                 notes_started;
    longint unsigned    env_span;
    longint unsigned    rel_span;

    always #2 i_clk = ~i_clk;

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_mix(out_ch.mix_out, out_ch.note_ended);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("ahdsr_envelope_scaler: mismatch");
                $finish;
            end
        end
    end

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        sb.write_reg(idx, val);
    endtask

    task automatic load_envelope(input longint unsigned d, a, h, dc, s, r);
        longint unsigned sum;
        put_reg(ahdsr_pkg::REG_DELAY, d);
        put_reg(ahdsr_pkg::REG_ATTACK, a);
        put_reg(ahdsr_pkg::REG_HOLD, h);
        put_reg(ahdsr_pkg::REG_DECAY, dc);
        put_reg(ahdsr_pkg::REG_SUSTAIN, s);
        put_reg(ahdsr_pkg::REG_RELEASE, r);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sum      = d + a + h + dc + 4;
        env_span = (sum > 60) ? 60 : sum;
        rel_span = (r + 3 > 30) ? 30 : r + 3;
    endtask

    task automatic offer_sample(input t_sample_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.base_sample <= it.base_sample;
        in_ch.mix_in      <= it.mix_in;
        in_ch.note_start  <= it.note_start;
        in_ch.release_now <= it.release_now;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_sample(it);
        items_sent++;
        if (it.note_start) notes_started++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_sample_item random_sample(bit st, bit rl);
        t_sample_item it;
        case ($urandom_range(7))
            0:       it.base_sample = {1'b0, {(SW-1){1'b1}}};
            1:       it.base_sample = {1'b1, {(SW-1){1'b0}}};
            default: it.base_sample = SW'($urandom);
        endcase
        case ($urandom_range(7))
            0:       it.mix_in = {1'b0, {(MIX_W-1){1'b1}}};
            1:       it.mix_in = {1'b1, {(MIX_W-1){1'b0}}};
            2:       it.mix_in = MIX_W'(int'($urandom_range(2000)) - 1000);
            default: it.mix_in = MIX_W'($urandom);
        endcase
        it.note_start  = st;
        it.release_now = rl;
        return it;
    endfunction

    // notes: start, a run through the envelope, usually a note-off, then the tail
    task automatic play_notes(input int count);
        int n, k, on_len, off_len;
        bit st, rl, with_release;
        n = 0;
        while (n < count) begin
            on_len       = $urandom_range(0, int'(env_span));
            off_len      = $urandom_range(0, int'(rel_span));
            with_release = ($urandom_range(5) != 0);
            for (k = 0; k <= on_len + off_len && n < count; k++) begin
                st = (k == 0);
                rl = with_release && (k == on_len);
                if ($urandom_range(24) == 0) begin
                    st = 1'($urandom_range(1));
                    rl = 1'($urandom_range(1));
                end
                offer_sample(random_sample(st, rl));
                n++;
            end
        end
    endtask

    function automatic longint unsigned pick_duration();
        return ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
    endfunction

    function automatic longint unsigned pick_sustain();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 65536;
            2:       return $urandom_range(65537, 131071);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    initial begin
        t_sample_item it;
        int           k, b, count;
        sb                = new();
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.base_sample = '0;
        in_ch.mix_in      = '0;
        in_ch.note_start  = 1'b0;
        in_ch.release_now = 1'b0;
        out_ch.ready      = 1'b0;
        hold_req          = 0;
        hold_left         = 0;
        stall_cycles      = 0;
        items_sent        = 0;
        notes_started     = 0;
        send_idle_pct     = 14;
        recv_idle_pct     = 83;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // silent after reset: pass-through, then a note-off with no note playing
        it = '{base_sample: 16'sh7FFF, mix_in: 24'sh7FFFFF, note_start: 1'b0,
               release_now: 1'b0};
        offer_sample(it);
        it = '{base_sample: 16'sh8000, mix_in: 24'sh800000, note_start: 1'b0,
               release_now: 1'b1};
        offer_sample(it);
        settle();

        // walk one note through every phase with full-scale values, then start and
        // note-off on the same item
        load_envelope(2, 3, 2, 4, 30000, 5);
        for (k = 0; k < 24; k++) begin
            it.base_sample = (k % 4 == 3) ? 16'sd0 : (k % 2 == 0) ? 16'sh7FFF : 16'sh8000;
            it.mix_in      = (k % 3 == 0) ? 24'sh7FFFFF :
                             (k % 3 == 1) ? 24'sh800000 : MIX_W'($urandom);
            it.note_start  = (k == 0 || k == 22);
            it.release_now = (k == 15 || k == 22);
            offer_sample(it);
        end
        settle();

        for (b = 0; b < SETTINGS_CNT; b++) begin
            if (b < 4) begin
                send_idle_pct = 14;
                recv_idle_pct = 83;
            end else if (b < 8) begin
                send_idle_pct = 83;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            count = 130;
            case (b)
                0: begin
                    // zero sustain and zero release: every note ends on its first item
                    load_envelope(0, 0, 0, 0, 0, 0);
                    count = 20;
                end
                1: begin
                    load_envelope(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, 131071, DUR_MAX);
                    count = 20;
                end
                5: begin
                    load_envelope(0, 0, 0, 0, 65536, 0);
                    count = 20;
                end
                default: begin
                    load_envelope(pick_duration(), pick_duration(), pick_duration(),
                                  pick_duration(), pick_sustain(),
                                  ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 10));
                end
            endcase
            if (b == 2 || b == 9) hold_req = 1;
            play_notes(count);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.errors += sb.pending();
        $display("run covered %0d samples in %0d notes over %0d envelope settings",
                 items_sent, notes_started, SETTINGS_CNT + 1);
        $display("results checked %0d, errors %0d", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("ahdsr_envelope_scaler: match");
        end else begin
            $display("ahdsr_envelope_scaler: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/ahdsr_pkg.sv
hw/rtl/ahdsr_in_if.sv
hw/rtl/ahdsr_out_if.sv
hw/rtl/ahdsr_envelope_scaler.sv
tb/sv/ahdsr_envelope_scaler_test.sv
